[rtl/pcs_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the streaming Pearson correlation block.
// No dependencies; every other file in rtl/ imports this package.
package pcs_pkg;

  // Largest number of subject pairs that one vector accumulates.
  localparam int MAX_SAMPLES = 65536;

  // Accumulator widths follow from the sample limit and a dosage of at most two.
  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W  = $clog2(2 * MAX_SAMPLES + 1);
  localparam int SQ_W   = $clog2(4 * MAX_SAMPLES + 1);
  // Variance and covariance terms, and the full products of two of them.
  localparam int VAR_W  = CNT_W + SQ_W;
  localparam int PROD_W = 2 * VAR_W;

  // Q1.15 result and the root search over its magnitude bits.
  localparam int Q_W    = 16;
  localparam int FRAC_W = Q_W - 1;
  localparam int LIM_W  = PROD_W + 2 * FRAC_W;
  localparam int CAND_W = PROD_W + 2 * Q_W;
  localparam int BIT_W  = $clog2(Q_W);

  localparam logic [Q_W-1:0] Q_ONE     = Q_W'(1) << FRAC_W;
  localparam logic [Q_W-1:0] Q_MAX_POS = Q_ONE - Q_W'(1);

  localparam logic [1:0] DOSE_MAX = 2'd2;

  // Vector queue between the accumulator and the arithmetic engine.
  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [1:0] x_value;
    logic [1:0] y_value;
    logic       last_pair;
  } pair_t;

  typedef struct packed {
    logic signed [Q_W-1:0] correlation;
    logic                  undefined;
  } result_t;

  // Closed sums of one vector.
  typedef struct packed {
    logic [CNT_W-1:0] sample_count;
    logic [SUM_W-1:0] sum_x;
    logic [SUM_W-1:0] sum_y;
    logic [SQ_W-1:0]  sum_x_squared;
    logic [SQ_W-1:0]  sum_y_squared;
    logic [SQ_W-1:0]  sum_x_times_y;
    logic             overflow_seen;
  } sums_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  typedef struct packed {
    logic             start;
    logic [VAR_W-1:0] a;
    logic [VAR_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] product;
  } mul_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_START,
    ST_MUL_WAIT,
    ST_CAND,
    ST_CMP,
    ST_OUT
  } state_e;

  // Product sequence of the engine.
  typedef enum logic [2:0] {
    STEP_N_SXX,
    STEP_SX_SX,
    STEP_N_SYY,
    STEP_SY_SY,
    STEP_N_SXY,
    STEP_SX_SY,
    STEP_DEN,
    STEP_NUM
  } mul_step_e;

endpackage

[rtl/pearson_correlation_stream.sv]
`timescale 1ns / 1ps
// Streaming Pearson correlation of paired dosages; uses pcs_pkg, pcs_accum, pcs_queue, pcs_engine.
// Throughput: one pair per cycle into the accumulator while the two-entry vector queue has room.
// Per vector the engine runs up to eight shift-add products (one multiplier bit per cycle; a product
// ends early once no multiplier bits are left) and a 16-bit root search that settles one bit per
// pass through ST_CAND and ST_CMP. Undefined vectors skip the last two products and the search.
// Reset is asynchronous and active low; it clears the sums, the queue and the engine at once.
module pearson_correlation_stream (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  pcs_pkg::pair_t   in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output pcs_pkg::result_t out_data_o
);
  import pcs_pkg::*;

  logic   push, pop;
  sums_t  push_data, head;
  qstat_t qstat;

  // Accumulate pairs and close vectors.
  pcs_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .qstat_i     (qstat),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // Buffer closed vectors.
  pcs_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .qstat_o     (qstat)
  );

  // Compute and deliver the coefficient.
  pcs_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .qhead_i     (head),
    .qstat_i     (qstat),
    .q_pop_o     (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

[rtl/pcs_accum.sv]
`timescale 1ns / 1ps
// Front end: takes subject pairs and keeps the running count and sums.
// Depends on pcs_pkg; hands closed vectors to pcs_queue.
module pcs_accum (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  pcs_pkg::pair_t in_data_i,
  input  pcs_pkg::qstat_t qstat_i,
  output logic           push_o,
  output pcs_pkg::sums_t push_data_o
);
  import pcs_pkg::*;

  sums_t      acc_q, acc_d, acc_next;
  logic       accept;
  logic [1:0] x_sat, y_sat;
  logic [2:0] x_sq, y_sq, xy;

  // Requests wait while the queue has no room for a closed vector.
  assign in_stall_o = qstat_i.full;
  assign accept     = in_valid_i && !in_stall_o;

  // Clamp the dosages and add the pair unless the count has saturated.
  always_comb begin
    x_sat = (in_data_i.x_value > DOSE_MAX) ? DOSE_MAX : in_data_i.x_value;
    y_sat = (in_data_i.y_value > DOSE_MAX) ? DOSE_MAX : in_data_i.y_value;
    x_sq  = 3'(x_sat) * 3'(x_sat);
    y_sq  = 3'(y_sat) * 3'(y_sat);
    xy    = 3'(x_sat) * 3'(y_sat);
    acc_next = acc_q;
    if (acc_q.sample_count >= CNT_W'(MAX_SAMPLES)) begin
      acc_next.overflow_seen = 1'b1;
    end else begin
      acc_next.sample_count  = acc_q.sample_count + CNT_W'(1);
      acc_next.sum_x         = acc_q.sum_x + SUM_W'(x_sat);
      acc_next.sum_y         = acc_q.sum_y + SUM_W'(y_sat);
      acc_next.sum_x_squared = acc_q.sum_x_squared + SQ_W'(x_sq);
      acc_next.sum_y_squared = acc_q.sum_y_squared + SQ_W'(y_sq);
      acc_next.sum_x_times_y = acc_q.sum_x_times_y + SQ_W'(xy);
    end
  end

  // The last pair closes the vector and clears the sums.
  always_comb begin
    acc_d = acc_q;
    if (accept) begin
      acc_d = in_data_i.last_pair ? '0 : acc_next;
    end
  end

  assign push_o      = accept && in_data_i.last_pair;
  assign push_data_o = acc_next;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

endmodule

[rtl/pcs_queue.sv]
`timescale 1ns / 1ps
// Short queue of closed vectors between the accumulator and the engine.
// Depends on pcs_pkg.
module pcs_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  pcs_pkg::sums_t  push_data_i,
  input  logic            pop_i,
  output pcs_pkg::sums_t  head_o,
  output pcs_pkg::qstat_t qstat_o
);
  import pcs_pkg::*;

  sums_t             data_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign head_o        = data_q[rd_ptr_q];
  assign qstat_o.full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign qstat_o.empty = (cnt_q == '0);

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      data_q[wr_ptr_q] <= push_data_i;
    end
  end

  // The accumulator must hold off while the queue is full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (cnt_q < QCNT_W'(QUEUE_DEPTH)))
    else $error("vector queue written while full");

  // The engine must not take a vector that is not there.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (cnt_q != '0))
    else $error("vector queue read while empty");

endmodule

[rtl/pcs_mul.sv]
`timescale 1ns / 1ps
// Shared shift-and-add multiplier, one multiplier bit per cycle.
// Depends on pcs_pkg; used by pcs_engine.
module pcs_mul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pcs_pkg::mul_req_t req_i,
  output pcs_pkg::mul_rsp_t rsp_o
);
  import pcs_pkg::*;

  logic              busy_q;
  logic [PROD_W-1:0] acc_q, a_q;
  logic [VAR_W-1:0]  b_q;

  // Done as soon as no multiplier bits are left.
  assign rsp_o.done    = busy_q && (b_q == '0);
  assign rsp_o.product = acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
    end else if (rsp_o.done) begin
      busy_q <= 1'b0;
    end
  end

  // Add the shifted multiplicand for each set multiplier bit.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q <= '0;
      a_q   <= PROD_W'(req_i.a);
      b_q   <= req_i.b;
    end else if (busy_q && (b_q != '0)) begin
      if (b_q[0]) begin
        acc_q <= acc_q + a_q;
      end
      a_q <= a_q << 1;
      b_q <= b_q >> 1;
    end
  end

endmodule

[rtl/pcs_engine.sv]
`timescale 1ns / 1ps
// Back end: forms the variance terms and the bitwise root of r squared.
// Depends on pcs_pkg and pcs_mul; takes vectors from pcs_queue.
module pcs_engine (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pcs_pkg::sums_t   qhead_i,
  input  pcs_pkg::qstat_t  qstat_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output pcs_pkg::result_t out_data_o
);
  import pcs_pkg::*;

  state_e            state_q, state_d;
  mul_step_e         step_q, step_d, step_next;
  logic [BIT_W-1:0]  bit_q, bit_d;

  mul_req_t          mul_req;
  mul_rsp_t          mul_rsp;

  sums_t             job_q;
  logic [PROD_W-1:0] tmp_q, den_q;
  logic [VAR_W-1:0]  vx_q, vy_q, mag_q;
  logic              neg_q;
  logic [LIM_W-1:0]  lim_q;
  logic [CAND_W-1:0] p_q, qs_q, d2_q, cand_q;
  logic [Q_W-1:0]    q_q, q_sel, q_clamp, corr_w;
  result_t           res_q;
  logic              undef_w, fit_w, prod_gt;

  pcs_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  assign undef_w = job_q.overflow_seen || (vx_q == '0) || (vy_q == '0);
  assign prod_gt = mul_rsp.product > tmp_q;

  // Product order through the shared multiplier.
  always_comb begin
    unique case (step_q)
      STEP_N_SXX: step_next = STEP_SX_SX;
      STEP_SX_SX: step_next = STEP_N_SYY;
      STEP_N_SYY: step_next = STEP_SY_SY;
      STEP_SY_SY: step_next = STEP_N_SXY;
      STEP_N_SXY: step_next = STEP_SX_SY;
      STEP_SX_SY: step_next = STEP_DEN;
      STEP_DEN:   step_next = STEP_NUM;
      STEP_NUM:   step_next = STEP_N_SXX;
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    bit_d   = bit_q;
    unique case (state_q)
      ST_IDLE: begin
        if (!qstat_i.empty) begin
          state_d = ST_MUL_START;
          step_d  = STEP_N_SXX;
        end
      end
      ST_MUL_START: state_d = ST_MUL_WAIT;
      ST_MUL_WAIT: begin
        if (mul_rsp.done) begin
          step_d = step_next;
          if ((step_q == STEP_SX_SY) && undef_w) begin
            state_d = ST_OUT;
          end else if (step_q == STEP_NUM) begin
            state_d = ST_CAND;
            bit_d   = BIT_W'(Q_W - 1);
          end else begin
            state_d = ST_MUL_START;
          end
        end
      end
      ST_CAND: state_d = ST_CMP;
      ST_CMP: begin
        if (bit_q == '0) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_CAND;
          bit_d   = bit_q - BIT_W'(1);
        end
      end
      ST_OUT: begin
        if (!out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs and multiplier operands.
  always_comb begin
    q_pop_o       = (state_q == ST_IDLE) && !qstat_i.empty;
    out_valid_o   = (state_q == ST_OUT);
    out_data_o    = res_q;
    mul_req.start = (state_q == ST_MUL_START);
    unique case (step_q)
      STEP_N_SXX: begin
        mul_req.a = VAR_W'(job_q.sample_count);
        mul_req.b = VAR_W'(job_q.sum_x_squared);
      end
      STEP_SX_SX: begin
        mul_req.a = VAR_W'(job_q.sum_x);
        mul_req.b = VAR_W'(job_q.sum_x);
      end
      STEP_N_SYY: begin
        mul_req.a = VAR_W'(job_q.sample_count);
        mul_req.b = VAR_W'(job_q.sum_y_squared);
      end
      STEP_SY_SY: begin
        mul_req.a = VAR_W'(job_q.sum_y);
        mul_req.b = VAR_W'(job_q.sum_y);
      end
      STEP_N_SXY: begin
        mul_req.a = VAR_W'(job_q.sample_count);
        mul_req.b = VAR_W'(job_q.sum_x_times_y);
      end
      STEP_SX_SY: begin
        mul_req.a = VAR_W'(job_q.sum_x);
        mul_req.b = VAR_W'(job_q.sum_y);
      end
      STEP_DEN: begin
        mul_req.a = vx_q;
        mul_req.b = vy_q;
      end
      STEP_NUM: begin
        mul_req.a = mag_q;
        mul_req.b = mag_q;
      end
    endcase
  end

  // One root bit: keep it if its trial square still fits under the limit.
  always_comb begin
    fit_w   = (cand_q <= CAND_W'(lim_q));
    q_sel   = fit_w ? (q_q | (Q_W'(1) << bit_q)) : q_q;
    q_clamp = (q_sel > Q_ONE) ? Q_ONE : q_sel;
    if (neg_q) begin
      corr_w = Q_W'(0) - q_clamp;
    end else begin
      corr_w = (q_clamp > Q_MAX_POS) ? Q_MAX_POS : q_clamp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= STEP_N_SXX;
      bit_q   <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      bit_q   <= bit_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      job_q <= qhead_i;
    end
    if ((state_q == ST_MUL_WAIT) && mul_rsp.done) begin
      unique case (step_q)
        STEP_N_SXX, STEP_N_SYY, STEP_N_SXY: tmp_q <= mul_rsp.product;
        STEP_SX_SX: vx_q <= VAR_W'(tmp_q - mul_rsp.product);
        STEP_SY_SY: vy_q <= VAR_W'(tmp_q - mul_rsp.product);
        STEP_SX_SY: begin
          neg_q <= prod_gt;
          mag_q <= prod_gt ? VAR_W'(mul_rsp.product - tmp_q)
                           : VAR_W'(tmp_q - mul_rsp.product);
          if (undef_w) begin
            res_q.correlation <= '0;
            res_q.undefined   <= 1'b1;
          end
        end
        STEP_DEN: den_q <= mul_rsp.product;
        STEP_NUM: begin
          lim_q <= LIM_W'(mul_rsp.product) << (2 * FRAC_W);
          d2_q  <= CAND_W'(den_q) << (2 * FRAC_W);
          p_q   <= '0;
          qs_q  <= '0;
          q_q   <= '0;
        end
      endcase
    end
    // Trial value (q + 2^b)^2 * den from the running terms.
    if (state_q == ST_CAND) begin
      cand_q <= p_q + qs_q + d2_q;
    end
    if (state_q == ST_CMP) begin
      if (fit_w) begin
        p_q  <= cand_q;
        qs_q <= (qs_q >> 1) + d2_q;
      end else begin
        qs_q <= qs_q >> 1;
      end
      d2_q <= d2_q >> 2;
      q_q  <= q_sel;
      if (bit_q == '0) begin
        res_q.correlation <= corr_w;
        res_q.undefined   <= 1'b0;
      end
    end
  end

  // Multiplier completions arrive only while the sequencer waits for them.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_rsp.done |-> (state_q == ST_MUL_WAIT))
    else $error("multiplier completion outside the wait state");

  // The accepted square never passes the limit during the root search.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CAND) |-> (p_q <= CAND_W'(lim_q)))
    else $error("root search kept a bit that overshoots");

  // An undefined result always carries a zero coefficient.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_OUT) && res_q.undefined) |-> (res_q.correlation == '0))
    else $error("undefined result with nonzero coefficient");

endmodule
